// ----- src/fpmd_pkg.sv -----
// Package with the transaction types and constants of the fixed-point multiply/divide unit.
package fpmd_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int WORD_W            = 32;

  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_DIV = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result;
    logic                     div_by_zero;
  } rsp_t;

endpackage

// ----- src/fixed_point_mul_div.sv -----
// Top level of the pipelined signed fixed-point multiply/divide unit.
//
// The unit takes one request transaction on the req channel (req_valid,
// req_stall, req) and returns exactly one response transaction on the rsp
// channel (rsp_valid, rsp_stall, rsp), in request order. A request carries a
// command (multiply or divide) and two signed fixed-point operands with
// FRAC_BITS fraction bits. Multiply returns the product truncated toward zero;
// divide returns (a << FRAC_BITS) / b truncated toward zero. Both keep the low
// 32 bits. A divide by zero returns zero with div_by_zero set.
//
// The pipeline takes a new request every cycle while the receiver does not stall
// a held response. Its length is set by the restoring divider, which resolves
// one quotient bit per stage over the 32 + FRAC_BITS bits of the shifted
// dividend; the multiply rides along the same stages.
//
// The whole pipeline advances as one unit. When a response waits in the output
// register and the receiver stalls, every stage holds and req_stall rises, so
// nothing is lost or repeated. Synchronous reset empties the pipeline.
module fixed_point_mul_div
  import fpmd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Bits of the shifted dividend magnitude, one divider stage for each.
  localparam int DVD_W = WORD_W + FRAC_BITS;
  localparam int NSTG  = DVD_W;

  // Pipeline registers, stage 0 is the input register.
  logic                vld    [0:NSTG];
  logic                cmd    [0:NSTG];
  logic                neg    [0:NSTG];
  logic                dz     [0:NSTG];
  logic [WORD_W-1:0]   dvsr   [0:NSTG-1];
  logic [WORD_W-1:0]   rem    [0:NSTG-1];
  logic [WORD_W-1:0]   quo    [0:NSTG];
  logic [DVD_W-1:0]    dvd    [0:NSTG-1];

  logic [WORD_W-1:0]   rem_next [1:NSTG-1];
  logic [WORD_W-1:0]   quo_next [1:NSTG];
  logic [DVD_W-1:0]    dvd_next [1:NSTG-1];

  logic                advance;
  logic [WORD_W-1:0]   mag_a;
  logic [WORD_W-1:0]   mag_b;
  logic [2*WORD_W-1:0] prod;
  logic signed [WORD_W-1:0] res_next;

  // The pipeline moves whenever the output register is free or being taken.
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;

  // Operand magnitudes; the most negative value maps to 2^31 exactly.
  assign mag_a = req.operand_a[WORD_W-1] ? WORD_W'(-req.operand_a) : WORD_W'(req.operand_a);
  assign mag_b = req.operand_b[WORD_W-1] ? WORD_W'(-req.operand_b) : WORD_W'(req.operand_b);

  // Full product of the magnitudes, formed in the first stage from stage 0.
  assign prod = (2*WORD_W)'(dvd[0][DVD_W-1 -: WORD_W]) * (2*WORD_W)'(dvsr[0]);

  // One restoring division step per stage. Only the low 32 quotient bits are
  // kept; a multiply carries its product in the quotient field instead.
  always_comb begin
    logic [WORD_W:0] trial;
    logic            qbit;
    for (int s = 1; s <= NSTG; s++) begin
      trial = {rem[s-1], dvd[s-1][DVD_W-1]};
      qbit  = (trial >= {1'b0, dvsr[s-1]});
      if (s == 1 && cmd[0] == CMD_MUL) begin
        quo_next[s] = prod[FRAC_BITS +: WORD_W];
      end else if (cmd[s-1] == CMD_MUL) begin
        quo_next[s] = quo[s-1];
      end else begin
        quo_next[s] = {quo[s-1][WORD_W-2:0], qbit};
      end
      if (s < NSTG) begin
        rem_next[s] = qbit ? WORD_W'(trial - {1'b0, dvsr[s-1]}) : trial[WORD_W-1:0];
        dvd_next[s] = {dvd[s-1][DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NSTG; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= req_valid;
      for (int s = 1; s <= NSTG; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd[0]  <= req.cmd;
      neg[0]  <= req.operand_a[WORD_W-1] ^ req.operand_b[WORD_W-1];
      dz[0]   <= (mag_b == '0);
      dvsr[0] <= mag_b;
      rem[0]  <= '0;
      quo[0]  <= '0;
      dvd[0]  <= {mag_a, FRAC_BITS'(0)};
      for (int s = 1; s <= NSTG; s++) begin
        cmd[s]  <= cmd[s-1];
        neg[s]  <= neg[s-1];
        dz[s]   <= dz[s-1];
        quo[s]  <= quo_next[s];
        if (s < NSTG) begin
          dvsr[s] <= dvsr[s-1];
          rem[s]  <= rem_next[s];
          dvd[s]  <= dvd_next[s];
        end
      end
    end
  end

  // Output stage: apply the sign and handle divide by zero.
  always_comb begin
    res_next = neg[NSTG] ? WORD_W'(-quo[NSTG]) : quo[NSTG];
    if (cmd[NSTG] == CMD_DIV && dz[NSTG]) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.result      <= res_next;
      rsp.div_by_zero <= (cmd[NSTG] == CMD_DIV) && dz[NSTG];
    end
  end

endmodule

// ----- src/fpmd_checker.sv -----
// Port-level checker for the fixed-point multiply/divide unit and its bind.
module fpmd_checker
  import fpmd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled response holds until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // The request side only stalls while a response is held back.
  a_req_stall: assert property (@(posedge clk)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a held response");

  // A divide by zero always reports a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_by_zero |-> rsp.result == '0)
    else $error("divide by zero with nonzero result");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind fixed_point_mul_div fpmd_checker u_fpmd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
